>>> rtl/core/fip_pkg.sv
// ---------------------------------------------------------------------------
// fip_pkg: shared types and constants for the binary64 integer power unit
// Holds FSM states, unit opcodes and control, float constants and classifiers.
// ---------------------------------------------------------------------------
package fip_pkg;

  localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] CANON_NAN    = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } fpu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SQ    = 3'd1,
    ST_SQW   = 3'd2,
    ST_MUL   = 3'd3,
    ST_MULW  = 3'd4,
    ST_DIV   = 3'd5,
    ST_DIVW  = 3'd6,
    ST_OUT   = 3'd7
  } seq_state_t;

  typedef enum logic [2:0] {
    FS_IDLE = 3'd0,
    FS_MUL  = 3'd1,
    FS_DIV  = 3'd2,
    FS_NORM = 3'd3,
    FS_RND  = 3'd4,
    FS_DONE = 3'd5,
    FS_PRE  = 3'd6
  } fpu_state_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
  } fpu_ctl_t;

  function automatic logic is_nan(input logic [63:0] b);
    is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] b);
    is_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] b);
    is_zero = (b[62:0] == 63'd0);
  endfunction

endpackage

>>> rtl/core/float64_integer_power_unit.sv
// ---------------------------------------------------------------------------
// float64_integer_power_unit: binary64 base raised to a signed 64-bit integer
// Square-and-multiply over one shared multicycle float unit.
// ---------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)
// in_     | in  | base_bits[63:0], exponent_value[127:64]
// out_    | out | power_bits[63:0]
// Denormal operands and underflow add normalize shifts to one operation.
// Up to 63 square and 62 multiply steps plus the divide for a negative
// exponent; zero base, zero exponent and magnitude one skip the loop.
// Reset is synchronous; one item in flight, in_tready low until the result
// beat is taken.
module float64_integer_power_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // base_bits, exponent_value
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata   // power_bits
);

  fip_pkg::seq_state_t state_r, state_nxt;
  logic [63:0] base_r, pow_r, orig_r, mag_r;
  logic        neg_r;
  fip_pkg::fpu_ctl_t ctl;
  logic [63:0] fa, fb, fy;
  logic        fdone;

  logic [63:0] ib, ie, imag;
  assign ib   = in_tdata[63:0];
  assign ie   = in_tdata[127:64];
  assign imag = ie[63] ? (64'd0 - ie) : ie;

  fip_fpu u_fpu (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .a    (fa),
    .b    (fb),
    .done (fdone),
    .y    (fy)
  );

  logic [63:0] fin;
  always_comb begin
    fin = pow_r;
    if (fip_pkg::is_nan(pow_r)) begin
      fin = fip_pkg::is_nan(orig_r) ? (orig_r | fip_pkg::QUIET_BIT) : fip_pkg::CANON_NAN;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.start = 1'b0;
    ctl.op    = fip_pkg::OP_MUL;
    fa        = base_r;
    fb        = base_r;
    unique case (state_r)
      fip_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (fip_pkg::is_zero(ib) || ie == 64'd0 || imag[63:1] == 63'd0) begin
            state_nxt = fip_pkg::ST_OUT;
            if (!fip_pkg::is_zero(ib) && ie[63]) begin
              state_nxt = fip_pkg::ST_DIV;
            end
          end else begin
            state_nxt = fip_pkg::ST_SQ;
          end
        end
      end
      fip_pkg::ST_SQ: begin
        ctl.start = 1'b1;
        state_nxt = fip_pkg::ST_SQW;
      end
      fip_pkg::ST_SQW: begin
        if (fdone) begin
          state_nxt = mag_r[0] ? fip_pkg::ST_MUL : fip_pkg::ST_SQ;
          if (!mag_r[0] && mag_r[63:1] == 63'd0) begin
            state_nxt = neg_r ? fip_pkg::ST_DIV : fip_pkg::ST_OUT;
          end
        end
      end
      fip_pkg::ST_MUL: begin
        ctl.start = 1'b1;
        fa        = pow_r;
        state_nxt = fip_pkg::ST_MULW;
      end
      fip_pkg::ST_MULW: begin
        fa = pow_r;
        if (fdone) begin
          if (mag_r[63:1] == 63'd0) begin
            state_nxt = neg_r ? fip_pkg::ST_DIV : fip_pkg::ST_OUT;
          end else begin
            state_nxt = fip_pkg::ST_SQ;
          end
        end
      end
      fip_pkg::ST_DIV: begin
        ctl.start = 1'b1;
        ctl.op    = fip_pkg::OP_DIV;
        fa        = fip_pkg::ONE_BITS;
        fb        = pow_r;
        state_nxt = fip_pkg::ST_DIVW;
      end
      fip_pkg::ST_DIVW: begin
        if (fdone) begin
          state_nxt = fip_pkg::ST_OUT;
        end
      end
      fip_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = fip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fip_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fip_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fip_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          base_r <= ib;
          orig_r <= ib;
          neg_r  <= ie[63];
          mag_r  <= {1'b0, imag[63:1]};
          if (fip_pkg::is_zero(ib)) begin
            pow_r <= ie[63] ? fip_pkg::POS_INF_BITS :
                     (ie == 64'd0) ? fip_pkg::ONE_BITS : 64'd0;
          end else if (ie == 64'd0) begin
            pow_r <= fip_pkg::ONE_BITS;
          end else begin
            pow_r <= imag[0] ? ib : fip_pkg::ONE_BITS;
          end
        end
      end
      fip_pkg::ST_SQW: begin
        if (fdone) begin
          base_r <= fy;
        end
      end
      fip_pkg::ST_MULW: begin
        if (fdone) begin
          pow_r <= fy;
          mag_r <= {1'b0, mag_r[63:1]};
        end
      end
      fip_pkg::ST_DIVW: begin
        if (fdone) begin
          pow_r <= fy;
        end
      end
      default: begin
      end
    endcase
    if (state_r == fip_pkg::ST_SQW && fdone && !mag_r[0]) begin
      mag_r <= {1'b0, mag_r[63:1]};
    end
  end

  assign in_tready  = (state_r == fip_pkg::ST_IDLE);
  assign out_tvalid = (state_r == fip_pkg::ST_OUT);
  assign out_tdata  = fin;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !ctl.start) else $error("double start");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

endmodule

>>> rtl/core/fip_fpu.sv
// ---------------------------------------------------------------------------
// fip_fpu: shared multicycle binary64 multiply and divide
// Multiply: 4 partial products of 27x27 over cycles. Divide: operands
// normalized first, then restoring, one quotient bit per cycle.
// Common normalize and round-to-nearest-even.
// ---------------------------------------------------------------------------
module fip_fpu (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fip_pkg::fpu_ctl_t    ctl,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  output logic                 done,
  output logic [63:0]          y
);

  fip_pkg::fpu_state_t state_r, state_nxt;

  logic         sign_r;
  logic signed [13:0] exp_r;
  logic [53:0]  ma_r, mb_r;
  logic [107:0] prod_r;
  logic [1:0]   pp_cnt_r;
  logic [6:0]   div_cnt_r;
  logic [54:0]  rem_r;
  logic [63:0]  y_r;
  logic         special_r;

  logic         sa, sb, za, zb, ia, ib, na, nb;
  logic [10:0]  ea, eb;
  logic [52:0]  fa, fb;
  logic signed [13:0] eua, eub;

  assign sa = a[63];
  assign sb = b[63];
  assign ea = a[62:52];
  assign eb = b[62:52];
  assign fa = {(ea != 11'd0), a[51:0]};
  assign fb = {(eb != 11'd0), b[51:0]};
  assign eua = (ea == 11'd0) ? 14'sd1 : $signed({3'b000, ea});
  assign eub = (eb == 11'd0) ? 14'sd1 : $signed({3'b000, eb});
  assign za = fip_pkg::is_zero(a);
  assign zb = fip_pkg::is_zero(b);
  assign ia = fip_pkg::is_inf(a);
  assign ib = fip_pkg::is_inf(b);
  assign na = fip_pkg::is_nan(a);
  assign nb = fip_pkg::is_nan(b);

  // partial product of 27-bit halves
  logic [26:0] pa, pb;
  logic [53:0] pp;
  always_comb begin
    pa = pp_cnt_r[0] ? ma_r[53:27] : ma_r[26:0];
    pb = pp_cnt_r[1] ? mb_r[53:27] : mb_r[26:0];
    pp = pa * pb;
  end

  // value = prod_r / 2^107 * 2^(exp_r - 1023); after normalize prod_r[107]
  // is the leading one, or exp_r is 1 for a denormal
  logic [52:0]  rm;
  logic         rg, rs, rinc;
  logic [53:0]  rsum;
  logic signed [13:0] rexp;
  logic [63:0]  rres;
  always_comb begin
    rm   = prod_r[107:55];
    rg   = prod_r[54];
    rs   = (prod_r[53:0] != 54'd0);
    rinc = rg & (rs | rm[0]);
    rsum = {1'b0, rm} + {53'd0, rinc};
    rexp = exp_r;
    if (rsum[53]) begin
      rexp = exp_r + 14'sd1;
    end
    if (rexp >= 14'sd2047) begin
      rres = {sign_r, 11'h7FF, 52'd0};
    end else if (rsum[53]) begin
      rres = {sign_r, rexp[10:0], rsum[52:1]};
    end else if (!rsum[52]) begin
      rres = {sign_r, 11'd0, rsum[51:0]};
    end else begin
      rres = {sign_r, rexp[10:0], rsum[51:0]};
    end
  end

  logic norm_right, norm_left;
  assign norm_right = (exp_r < 14'sd1);
  assign norm_left  = !prod_r[107] && (exp_r > 14'sd1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fip_pkg::FS_IDLE: begin
        if (ctl.start) begin
          if (ctl.op == fip_pkg::OP_MUL) begin
            state_nxt = fip_pkg::FS_MUL;
          end else begin
            state_nxt = fip_pkg::FS_PRE;
          end
        end
      end
      fip_pkg::FS_PRE: begin
        if (special_r || (rem_r[52] && mb_r[52])) begin
          state_nxt = special_r ? fip_pkg::FS_DONE : fip_pkg::FS_DIV;
        end
      end
      fip_pkg::FS_MUL: begin
        if (special_r || pp_cnt_r == 2'd3) begin
          state_nxt = special_r ? fip_pkg::FS_DONE : fip_pkg::FS_NORM;
        end
      end
      fip_pkg::FS_DIV: begin
        if (div_cnt_r == 7'd0) begin
          state_nxt = fip_pkg::FS_NORM;
        end
      end
      fip_pkg::FS_NORM: begin
        if (!norm_right && !norm_left) begin
          state_nxt = fip_pkg::FS_RND;
        end
      end
      fip_pkg::FS_RND: state_nxt = fip_pkg::FS_DONE;
      fip_pkg::FS_DONE: state_nxt = fip_pkg::FS_IDLE;
      default: state_nxt = fip_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fip_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  logic [55:0] trial;
  logic        div_ge;
  logic [54:0] rem_new;
  assign trial   = {1'b0, rem_r} - {2'b00, mb_r};
  assign div_ge  = !trial[55];
  assign rem_new = div_ge ? trial[54:0] : rem_r;

  always_ff @(posedge clk) begin
    unique case (state_r)
      fip_pkg::FS_IDLE: begin
        if (ctl.start) begin
          sign_r    <= sa ^ sb;
          pp_cnt_r  <= 2'd0;
          prod_r    <= 108'd0;
          ma_r      <= {1'b0, fa};
          mb_r      <= {1'b0, fb};
          rem_r     <= {2'b00, fa};
          div_cnt_r <= 7'd107;
          if (ctl.op == fip_pkg::OP_MUL) begin
            exp_r <= eua + eub - 14'sd1020;
          end else begin
            exp_r <= eua - eub + 14'sd1023;
          end
          if (na || nb) begin
            special_r <= 1'b1;
            y_r       <= fip_pkg::CANON_NAN;
          end else if (ctl.op == fip_pkg::OP_MUL) begin
            if ((ia && zb) || (za && ib)) begin
              special_r <= 1'b1;
              y_r       <= fip_pkg::CANON_NAN;
            end else if (ia || ib) begin
              special_r <= 1'b1;
              y_r       <= {sa ^ sb, 11'h7FF, 52'd0};
            end else if (za || zb) begin
              special_r <= 1'b1;
              y_r       <= {sa ^ sb, 63'd0};
            end else begin
              special_r <= 1'b0;
            end
          end else begin
            if ((ia && ib) || (za && zb)) begin
              special_r <= 1'b1;
              y_r       <= fip_pkg::CANON_NAN;
            end else if (ia || zb) begin
              special_r <= 1'b1;
              y_r       <= {sa ^ sb, 11'h7FF, 52'd0};
            end else if (za || ib) begin
              special_r <= 1'b1;
              y_r       <= {sa ^ sb, 63'd0};
            end else begin
              special_r <= 1'b0;
            end
          end
        end
      end
      fip_pkg::FS_PRE: begin
        if (!special_r) begin
          if (!rem_r[52]) begin
            rem_r <= {rem_r[53:0], 1'b0};
          end
          if (!mb_r[52]) begin
            mb_r <= {mb_r[52:0], 1'b0};
          end
          if (!rem_r[52] && mb_r[52]) begin
            exp_r <= exp_r - 14'sd1;
          end else if (rem_r[52] && !mb_r[52]) begin
            exp_r <= exp_r + 14'sd1;
          end
        end
      end
      fip_pkg::FS_MUL: begin
        if (!special_r) begin
          prod_r   <= prod_r + ({54'd0, pp} << (27 * ({5'd0, pp_cnt_r[0]} + {5'd0, pp_cnt_r[1]})));
          pp_cnt_r <= pp_cnt_r + 2'd1;
        end
      end
      fip_pkg::FS_DIV: begin
        // last bit also carries the remainder as sticky
        rem_r     <= {rem_new[53:0], 1'b0};
        prod_r    <= {prod_r[106:0],
                      div_ge | ((div_cnt_r == 7'd0) && (rem_new != 55'd0))};
        div_cnt_r <= div_cnt_r - 7'd1;
      end
      fip_pkg::FS_NORM: begin
        if (norm_right) begin
          if (exp_r < -14'sd120) begin
            prod_r <= {107'd0, (prod_r != 108'd0)};
            exp_r  <= 14'sd1;
          end else begin
            prod_r <= {1'b0, prod_r[107:2], prod_r[1] | prod_r[0]};
            exp_r  <= exp_r + 14'sd1;
          end
        end else if (norm_left) begin
          prod_r <= {prod_r[106:0], 1'b0};
          exp_r  <= exp_r - 14'sd1;
        end
      end
      fip_pkg::FS_RND: begin
        y_r <= rres;
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == fip_pkg::FS_DONE);
  assign y    = y_r;

endmodule
